[rtl/core/cpt_pkg.sv]
// Shared types, widths and codes for the point-to-triangle clamp.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package cpt_pkg;

	localparam int FRAC_BITS = 8;
	localparam int IN_W      = 14;
	localparam int OUT_W     = 22;
	localparam int VTX_W     = 12;
	localparam int HGT_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = HGT_W;

	// Upward coordinates, edge coefficients and wide products.
	localparam int CRD_W = 16;
	localparam int DIF_W = CRD_W + 1;
	localparam int ORI_W = 2 * DIF_W;
	localparam int MUL_W = DIF_W + CRD_W;
	localparam int C_W   = 32;
	localparam int PRD_W = DIF_W + C_W;
	localparam int NUM_W = PRD_W;
	localparam int DEN_W = C_W;
	localparam int REM_W = NUM_W + FRAC_BITS;
	localparam int QB    = OUT_W;
	localparam int DIV_STAGES = QB + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [OUT_W-1:0] MAG_NEG_LIM = OUT_W'(1) << (OUT_W - 1);
	localparam logic [OUT_W-1:0] MAG_POS_LIM = MAG_NEG_LIM - OUT_W'(1);
	localparam logic [OUT_W-1:0] FRAC_MASK   = (OUT_W'(1) << FRAC_BITS) - OUT_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_APEX_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APEX_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd6;

	localparam logic [1:0] CODE_SAME   = 2'd0;
	localparam logic [1:0] CODE_VERTEX = 2'd1;
	localparam logic [1:0] CODE_PROJ   = 2'd2;
	localparam logic [1:0] CODE_DEGEN  = 2'd3;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic signed [DIF_W-1:0] dif_t;

	typedef struct packed {
		logic [VTX_W-1:0] apex_x;
		logic [VTX_W-1:0] apex_y;
		logic [VTX_W-1:0] left_x;
		logic [VTX_W-1:0] left_y;
		logic [VTX_W-1:0] right_x;
		logic [VTX_W-1:0] right_y;
		logic [HGT_W-1:0] screen_height;
	} cfg_t;

	// Result known at classification time, carried alongside the arithmetic.
	typedef struct packed {
		logic                   direct;
		logic                   degen;
		logic [1:0]             code;
		logic signed [IN_W-1:0] dx;
		logic signed [IN_W-1:0] dy;
	} side_t;

	typedef struct packed {
		side_t side;
		crd_t  p;
		crd_t  q;
		crd_t  s;
		crd_t  t;
		crd_t  u;
		crd_t  v;
		crd_t  w;
		crd_t  z;
	} job_t;

	typedef struct packed {
		side_t            side;
		logic             neg_x;
		logic             neg_y;
		logic [NUM_W-1:0] num_x;
		logic [NUM_W-1:0] num_y;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

[rtl/core/clamp_point_to_triangle_top.sv]
// Top level of the point-to-triangle clamp: register file, front end, queue,
// back end, divider and output register. Depends on cpt_pkg and all cpt_* modules.
`default_nettype none
// One point enters per cycle and one result leaves per cycle when out_ready
// stays high. A point passes through two classification stages, the queue,
// four coefficient and product stages, 23 divider stages (an overflow check,
// then one quotient bit each) and the output register. The front end keeps
// taking points into a four-entry queue while the output is stalled, until
// the queue is full. Vertex and height registers are written through the cfg
// port, which is always ready; write them only while no point is in flight.
module clamp_point_to_triangle_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [cpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cpt_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic signed [cpt_pkg::IN_W-1:0] point_x,
	input  wire logic signed [cpt_pkg::IN_W-1:0] point_y,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic signed [cpt_pkg::OUT_W-1:0] out_x,
	output logic signed [cpt_pkg::OUT_W-1:0] out_y,
	output logic [1:0] case_code
);
	import cpt_pkg::*;

	cfg_t cfg_q;
	logic job_valid, fifo_full, fifo_empty, fifo_push, fifo_pop;
	job_t job_in, job_out;
	logic en;
	logic req_valid, res_valid;
	div_req_t req;
	side_t res_side;
	logic signed [OUT_W-1:0] res_x, res_y;
	logic out_valid_q;
	logic signed [OUT_W-1:0] out_x_q, out_y_q;
	logic [1:0] code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.apex_x        <= VTX_W'(512);
			cfg_q.apex_y        <= VTX_W'(100);
			cfg_q.left_x        <= VTX_W'(100);
			cfg_q.left_y        <= VTX_W'(800);
			cfg_q.right_x       <= VTX_W'(924);
			cfg_q.right_y       <= VTX_W'(800);
			cfg_q.screen_height <= HGT_W'(1024);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_APEX_X:  cfg_q.apex_x        <= cfg_data[VTX_W-1:0];
				REG_APEX_Y:  cfg_q.apex_y        <= cfg_data[VTX_W-1:0];
				REG_LEFT_X:  cfg_q.left_x        <= cfg_data[VTX_W-1:0];
				REG_LEFT_Y:  cfg_q.left_y        <= cfg_data[VTX_W-1:0];
				REG_RIGHT_X: cfg_q.right_x       <= cfg_data[VTX_W-1:0];
				REG_RIGHT_Y: cfg_q.right_y       <= cfg_data[VTX_W-1:0];
				REG_HEIGHT:  cfg_q.screen_height <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	cpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.job_valid (job_valid),
		.job_ready (!fifo_full),
		.job       (job_in)
	);

	assign fifo_push = job_valid && !fifo_full;
	assign en        = !out_valid_q || out_ready;
	assign fifo_pop  = en && !fifo_empty;

	cpt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (job_in),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.dout   (job_out),
		.empty  (fifo_empty)
	);

	cpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.height    (cfg_q.screen_height),
		.job_valid (!fifo_empty),
		.job       (job_out),
		.req_valid (req_valid),
		.req       (req)
	);

	cpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.req       (req),
		.res_valid (res_valid),
		.res_side  (res_side),
		.res_x     (res_x),
		.res_y     (res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (res_side.direct) begin
				out_x_q <= OUT_W'(res_side.dx) <<< FRAC_BITS;
				out_y_q <= OUT_W'(res_side.dy) <<< FRAC_BITS;
				code_q  <= res_side.code;
			end else if (res_side.degen) begin
				out_x_q <= '0;
				out_y_q <= '0;
				code_q  <= CODE_DEGEN;
			end else begin
				out_x_q <= res_x;
				out_y_q <= res_y;
				code_q  <= CODE_PROJ;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign case_code = code_q;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && case_code == CODE_DEGEN |-> out_x == '0 && out_y == '0)
		else $error("degenerate result is not zero");

	a_direct_integer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (case_code == CODE_SAME || case_code == CODE_VERTEX)
		|-> (out_x & FRAC_MASK) == '0 && (out_y & FRAC_MASK) == '0)
		else $error("unchanged or vertex result has fraction bits");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> fifo_full && job_valid)
		else $error("input stalled while the queue has room");
`endif

endmodule
`default_nettype wire

[rtl/core/cpt_front.sv]
// Front end: flips the point, runs the three orientation tests and classifies it.
// Depends on cpt_pkg; emits one job beat per point toward the queue.
`default_nettype none
module cpt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  cpt_pkg::cfg_t      cfg,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic signed [cpt_pkg::IN_W-1:0] point_x,
	input  wire logic signed [cpt_pkg::IN_W-1:0] point_y,
	output logic               job_valid,
	input  wire logic          job_ready,
	output cpt_pkg::job_t      job
);
	import cpt_pkg::*;

	localparam logic [2:0] PICK_M  = 3'd0;
	localparam logic [2:0] PICK_A  = 3'd1;
	localparam logic [2:0] PICK_L  = 3'd2;
	localparam logic [2:0] PICK_R  = 3'd3;
	localparam logic [2:0] CUT_L   = 3'd4;
	localparam logic [2:0] CUT_R   = 3'd5;
	localparam logic [2:0] CUT_D   = 3'd6;

	logic en;
	logic v_s1, v_s2;
	logic signed [IN_W-1:0] px_s1, py_s1, px_s2, py_s2;
	crd_t mx_s2, my_s2;
	logic signed [ORI_W-1:0] l1_s2, l2_s2, r1_s2, r2_s2, d1_s2, d2_s2;

	crd_t h, ax, ay, lx, ly, rx, ry, mx, my;
	dif_t my_ly, ax_mx, mx_lx, ay_my, my_ry, mx_rx, rx_mx, ry_my;
	logic signed [ORI_W-1:0] vl, vr, vd;
	logic [2:0] pick;

	assign en       = !v_s2 || job_ready;
	assign in_ready = en;

	assign h  = crd_t'(cfg.screen_height);
	assign ax = crd_t'(cfg.apex_x);
	assign ay = h - crd_t'(cfg.apex_y);
	assign lx = crd_t'(cfg.left_x);
	assign ly = h - crd_t'(cfg.left_y);
	assign rx = crd_t'(cfg.right_x);
	assign ry = h - crd_t'(cfg.right_y);
	assign mx = crd_t'(px_s1);
	assign my = h - crd_t'(py_s1);

	assign my_ly = dif_t'(my) - dif_t'(ly);
	assign ax_mx = dif_t'(ax) - dif_t'(mx);
	assign mx_lx = dif_t'(mx) - dif_t'(lx);
	assign ay_my = dif_t'(ay) - dif_t'(my);
	assign my_ry = dif_t'(my) - dif_t'(ry);
	assign mx_rx = dif_t'(mx) - dif_t'(rx);
	assign rx_mx = dif_t'(rx) - dif_t'(mx);
	assign ry_my = dif_t'(ry) - dif_t'(my);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= point_x;
			py_s1 <= point_y;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			mx_s2 <= mx;
			my_s2 <= my;
			l1_s2 <= my_ly * ax_mx;
			l2_s2 <= mx_lx * ay_my;
			r1_s2 <= my_ry * ax_mx;
			r2_s2 <= mx_rx * ay_my;
			d1_s2 <= my_ly * rx_mx;
			d2_s2 <= mx_lx * ry_my;
		end
	end

	assign vl = l1_s2 - l2_s2;
	assign vr = r1_s2 - r2_s2;
	assign vd = d1_s2 - d2_s2;

	always_comb begin
		logic bl, br, bd;
		bl = (vl != '0) && !vl[ORI_W-1];
		br = vr[ORI_W-1];
		bd = vd[ORI_W-1];
		if (vl == '0) begin
			pick = (my_s2 > ay) ? PICK_A : (my_s2 < ly) ? PICK_L : PICK_M;
		end else if (vr == '0) begin
			pick = (my_s2 > ay) ? PICK_A : (my_s2 < ry) ? PICK_R : PICK_M;
		end else if (vd == '0) begin
			pick = (mx_s2 < lx) ? PICK_L : (mx_s2 > rx) ? PICK_R : PICK_M;
		end else if (!bl && !br && !bd) begin
			pick = PICK_M;
		end else if (bl && br) begin
			pick = PICK_A;
		end else if (br && bd) begin
			pick = PICK_R;
		end else if (bl && bd) begin
			pick = PICK_L;
		end else if (bl) begin
			pick = CUT_L;
		end else if (br) begin
			pick = CUT_R;
		end else begin
			pick = CUT_D;
		end
	end

	always_comb begin
		job = '0;
		job.side.direct = 1'b1;
		job.side.degen  = 1'b0;
		job.side.code   = CODE_VERTEX;
		case (pick)
			PICK_M: begin
				job.side.code = CODE_SAME;
				job.side.dx   = px_s2;
				job.side.dy   = py_s2;
			end
			PICK_A: begin
				job.side.dx = IN_W'(cfg.apex_x);
				job.side.dy = IN_W'(cfg.apex_y);
			end
			PICK_L: begin
				job.side.dx = IN_W'(cfg.left_x);
				job.side.dy = IN_W'(cfg.left_y);
			end
			PICK_R: begin
				job.side.dx = IN_W'(cfg.right_x);
				job.side.dy = IN_W'(cfg.right_y);
			end
			CUT_L: begin
				job.side.direct = 1'b0;
				job.side.code   = CODE_PROJ;
				job.p = ax; job.q = ay; job.s = lx; job.t = ly;
				job.u = mx_s2; job.v = my_s2; job.w = rx; job.z = ry;
			end
			CUT_R: begin
				job.side.direct = 1'b0;
				job.side.code   = CODE_PROJ;
				job.p = ax; job.q = ay; job.s = rx; job.t = ry;
				job.u = lx; job.v = ly; job.w = mx_s2; job.z = my_s2;
			end
			default: begin
				job.side.direct = 1'b0;
				job.side.code   = CODE_PROJ;
				job.p = lx; job.q = ly; job.s = rx; job.t = ry;
				job.u = mx_s2; job.v = my_s2; job.w = ax; job.z = ay;
			end
		endcase
	end

	assign job_valid = v_s2;

endmodule
`default_nettype wire

[rtl/core/cpt_fifo.sv]
// Short job queue between the classifier and the arithmetic back end.
// Depends on cpt_pkg for the job type and depth.
`default_nettype none
module cpt_fifo (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  cpt_pkg::job_t din,
	output logic          full,
	input  wire logic     pop,
	output cpt_pkg::job_t dout,
	output logic          empty
);
	import cpt_pkg::*;

	job_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

[rtl/core/cpt_back.sv]
// Back end: edge coefficients, determinant and the two signed numerators.
// Depends on cpt_pkg; feeds magnitudes and signs to the divider.
`default_nettype none
module cpt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [cpt_pkg::HGT_W-1:0] height,
	input  wire logic          job_valid,
	input  cpt_pkg::job_t      job,
	output logic               req_valid,
	output cpt_pkg::div_req_t  req
);
	import cpt_pkg::*;

	logic  v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3;
	dif_t  a1_s1, b1_s1, a2_s1, b2_s1, a1_s2, b1_s2, a2_s2, b2_s2;
	crd_t  p_s1, q_s1, u_s1, v2_s1;
	logic signed [C_W-1:0]   c1_s2, c2_s2, det_s2, det_s3;
	logic signed [PRD_W-1:0] bc1_s3, bc2_s3, ac2_s3, ac1_s3, hd_s3;
	logic degen_s3;
	div_req_t req_s4;

	logic signed [MUL_W-1:0] m1, m2, m3, m4;
	logic signed [ORI_W-1:0] dt1, dt2;
	logic signed [HGT_W:0]   hs;
	logic signed [NUM_W-1:0] nx, ny;
	logic signed [C_W-1:0]   dabs;
	side_t side_d;

	assign m1  = a1_s1 * p_s1;
	assign m2  = b1_s1 * q_s1;
	assign m3  = a2_s1 * u_s1;
	assign m4  = b2_s1 * v2_s1;
	assign dt1 = a1_s1 * b2_s1;
	assign dt2 = a2_s1 * b1_s1;
	assign hs  = signed'({1'b0, height});

	// Exact values stay below 2^47, so the subtractions cannot wrap.
	assign nx   = bc1_s3 - bc2_s3;
	assign ny   = hd_s3 - (ac2_s3 - ac1_s3);
	assign dabs = det_s3[C_W-1] ? -det_s3 : det_s3;

	always_comb begin
		side_d       = side_s3;
		side_d.degen = degen_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= job_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= job.side;
			a1_s1   <= dif_t'(job.t) - dif_t'(job.q);
			b1_s1   <= dif_t'(job.p) - dif_t'(job.s);
			a2_s1   <= dif_t'(job.z) - dif_t'(job.v);
			b2_s1   <= dif_t'(job.u) - dif_t'(job.w);
			p_s1    <= job.p;
			q_s1    <= job.q;
			u_s1    <= job.u;
			v2_s1   <= job.v;

			side_s2 <= side_s1;
			a1_s2   <= a1_s1;
			b1_s2   <= b1_s1;
			a2_s2   <= a2_s1;
			b2_s2   <= b2_s1;
			c1_s2   <= C_W'(m1) + C_W'(m2);
			c2_s2   <= C_W'(m3) + C_W'(m4);
			det_s2  <= C_W'(dt1) - C_W'(dt2);

			side_s3  <= side_s2;
			bc1_s3   <= b2_s2 * c1_s2;
			bc2_s3   <= b1_s2 * c2_s2;
			ac2_s3   <= a1_s2 * c2_s2;
			ac1_s3   <= a2_s2 * c1_s2;
			hd_s3    <= hs * det_s2;
			det_s3   <= det_s2;
			degen_s3 <= (det_s2 == '0);

			req_s4.side       <= side_d;
			req_s4.neg_x      <= nx[NUM_W-1] ^ det_s3[C_W-1];
			req_s4.neg_y      <= ny[NUM_W-1] ^ det_s3[C_W-1];
			req_s4.num_x      <= nx[NUM_W-1] ? -nx : nx;
			req_s4.num_y      <= ny[NUM_W-1] ? -ny : ny;
			// A zero determinant is overridden at the output; keep the divider tame.
			req_s4.den        <= degen_s3 ? DEN_W'(1) : dabs;
		end
	end

	assign req_valid = v_s4;
	assign req       = req_s4;

endmodule
`default_nettype wire

[rtl/core/cpt_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage.
// Depends on cpt_pkg; gives truncated, saturated fixed-point quotients.
`default_nettype none
module cpt_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         req_valid,
	input  cpt_pkg::div_req_t req,
	output logic              res_valid,
	output cpt_pkg::side_t    res_side,
	output logic signed [cpt_pkg::OUT_W-1:0] res_x,
	output logic signed [cpt_pkg::OUT_W-1:0] res_y
);
	import cpt_pkg::*;

	logic             vld_q  [DIV_STAGES];
	side_t            side_q [DIV_STAGES];
	logic [DEN_W-1:0] den_q  [DIV_STAGES];
	logic [REM_W-1:0] rem_q  [2][DIV_STAGES];
	logic [QB-1:0]    quo_q  [2][DIV_STAGES];
	logic             ovf_q  [2][DIV_STAGES];
	logic             neg_q  [2][DIV_STAGES];

	logic [NUM_W-1:0] num_in [2];
	logic             neg_in [2];
	logic signed [OUT_W-1:0] res [2];

	assign num_in[0] = req.num_x;
	assign num_in[1] = req.num_y;
	assign neg_in[0] = req.neg_x;
	assign neg_in[1] = req.neg_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= req_valid;
			for (int i = 1; i < DIV_STAGES; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= req.side;
			den_q[0]  <= req.den;
			for (int i = 1; i < DIV_STAGES; i++) begin
				side_q[i] <= side_q[i-1];
				den_q[i]  <= den_q[i-1];
			end
		end
	end

	genvar ln, k;
	generate
		for (ln = 0; ln < 2; ln++) begin : g_lane
			logic [REM_W-1:0] rem0;
			assign rem0 = REM_W'(num_in[ln]) << FRAC_BITS;

			// The first stage only decides whether the quotient overflows QB bits.
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[ln][0] <= rem0;
					quo_q[ln][0] <= '0;
					ovf_q[ln][0] <= (rem0 >= (REM_W'(req.den) << QB));
					neg_q[ln][0] <= neg_in[ln];
				end
			end

			for (k = 1; k < DIV_STAGES; k++) begin : g_stage
				localparam int B = QB - k;
				logic [REM_W-1:0] trial;
				logic take;
				assign trial = REM_W'(den_q[k-1]) << B;
				assign take  = !ovf_q[ln][k-1] && (rem_q[ln][k-1] >= trial);
				always_ff @(posedge clk) begin
					if (en) begin
						rem_q[ln][k] <= take ? rem_q[ln][k-1] - trial : rem_q[ln][k-1];
						quo_q[ln][k] <= quo_q[ln][k-1] | (take ? (QB'(1) << B) : '0);
						ovf_q[ln][k] <= ovf_q[ln][k-1];
						neg_q[ln][k] <= neg_q[ln][k-1];
					end
				end
			end

			always_comb begin
				logic [QB-1:0] mag;
				logic neg;
				mag = quo_q[ln][DIV_STAGES-1];
				neg = neg_q[ln][DIV_STAGES-1];
				if (neg) begin
					res[ln] = (ovf_q[ln][DIV_STAGES-1] || mag > MAG_NEG_LIM) ?
						signed'(MAG_NEG_LIM) : -signed'(mag);
				end else begin
					res[ln] = (ovf_q[ln][DIV_STAGES-1] || mag > MAG_POS_LIM) ?
						signed'(MAG_POS_LIM) : signed'(mag);
				end
			end
		end
	endgenerate

	assign res_valid = vld_q[DIV_STAGES-1];
	assign res_side  = side_q[DIV_STAGES-1];
	assign res_x     = res[0];
	assign res_y     = res[1];

endmodule
`default_nettype wire

[dv/tb_clamp_point_to_triangle_top.sv]
// Self-checking bench for clamp_point_to_triangle_top: drives points, writes vertex
// and height registers between phases, and checks every result against a predictor.
// Depends on cpt_pkg and the clamp_point_to_triangle_top RTL only.
`default_nettype none

module tb_clamp_point_to_triangle_top;
	import cpt_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN = 10;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	localparam longint SAT_MAX = 64'sd2097151;
	localparam longint SAT_MIN = -64'sd2097152;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [1:0] code;
	} clamp_result_t;

	class clamp_scoreboard;
		longint apex_x, apex_y, left_x, left_y, right_x, right_y, height;
		clamp_result_t expected_q[$];
		int mismatches;
		int checked;

		function new();
			apex_x = 512; apex_y = 100;
			left_x = 100; left_y = 800;
			right_x = 924; right_y = 800;
			height = 1024;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_APEX_X:  apex_x = longint'(data[VTX_W-1:0]);
				REG_APEX_Y:  apex_y = longint'(data[VTX_W-1:0]);
				REG_LEFT_X:  left_x = longint'(data[VTX_W-1:0]);
				REG_LEFT_Y:  left_y = longint'(data[VTX_W-1:0]);
				REG_RIGHT_X: right_x = longint'(data[VTX_W-1:0]);
				REG_RIGHT_Y: right_y = longint'(data[VTX_W-1:0]);
				REG_HEIGHT:  height = longint'(data);
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > SAT_MAX) return SAT_MAX;
			if (v < SAT_MIN) return SAT_MIN;
			return v;
		endfunction

		function longint fixed_quotient(longint num, longint den);
			longint q, r, lim;
			q = num / den;
			r = num % den;
			lim = 64'sd1 << 22;
			if (q > lim) q = lim;
			if (q < -lim) q = -lim;
			return sat(q * (64'sd1 << FRAC_BITS) + (r * (64'sd1 << FRAC_BITS)) / den);
		endfunction

		// 0 collinear, 1 positive turn, 2 negative turn.
		function int turn(longint x1, longint y1, longint x2, longint y2,
				longint x3, longint y3);
			longint v;
			v = (y2 - y1) * (x3 - x2) - (x2 - x1) * (y3 - y2);
			if (v == 0) return 0;
			return (v > 0) ? 1 : 2;
		endfunction

		function clamp_result_t place(longint x, longint y_up, logic [1:0] code);
			clamp_result_t r;
			r.x = OUT_W'(sat(x * (64'sd1 << FRAC_BITS)));
			r.y = OUT_W'(sat((height - y_up) * (64'sd1 << FRAC_BITS)));
			r.code = code;
			return r;
		endfunction

		function clamp_result_t clamp(logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py);
			longint mx, my, ax, ay, lx, ly, rx, ry;
			longint p, q, s, t, u, v, w, z, a1, b1, c1, a2, b2, c2, det;
			int o_l, o_r, o_d;
			bit out_l, out_r, out_d;
			clamp_result_t r;
			mx = longint'(px); my = height - longint'(py);
			ax = apex_x; ay = height - apex_y;
			lx = left_x; ly = height - left_y;
			rx = right_x; ry = height - right_y;
			o_l = turn(lx, ly, mx, my, ax, ay);
			o_r = turn(rx, ry, mx, my, ax, ay);
			o_d = turn(lx, ly, mx, my, rx, ry);
			if (o_l == 0) begin
				if (my > ay) return place(ax, ay, CODE_VERTEX);
				if (my < ly) return place(lx, ly, CODE_VERTEX);
				return place(mx, my, CODE_SAME);
			end
			if (o_r == 0) begin
				if (my > ay) return place(ax, ay, CODE_VERTEX);
				if (my < ry) return place(rx, ry, CODE_VERTEX);
				return place(mx, my, CODE_SAME);
			end
			if (o_d == 0) begin
				if (mx < lx) return place(lx, ly, CODE_VERTEX);
				if (mx > rx) return place(rx, ry, CODE_VERTEX);
				return place(mx, my, CODE_SAME);
			end
			out_l = (o_l == 1);
			out_r = (o_r == 2);
			out_d = (o_d == 2);
			if (!out_l && !out_r && !out_d) return place(mx, my, CODE_SAME);
			if (out_l && out_r) return place(ax, ay, CODE_VERTEX);
			if (out_r && out_d) return place(rx, ry, CODE_VERTEX);
			if (out_l && out_d) return place(lx, ly, CODE_VERTEX);
			// The crossed edge is intersected with the line from the point
			// to the opposite vertex.
			if (out_l) begin
				p = ax; q = ay; s = lx; t = ly; u = mx; v = my; w = rx; z = ry;
			end else if (out_r) begin
				p = ax; q = ay; s = rx; t = ry; u = lx; v = ly; w = mx; z = my;
			end else begin
				p = lx; q = ly; s = rx; t = ry; u = mx; v = my; w = ax; z = ay;
			end
			a1 = t - q; b1 = p - s; c1 = a1 * p + b1 * q;
			a2 = z - v; b2 = u - w; c2 = a2 * u + b2 * v;
			det = a1 * b2 - a2 * b1;
			if (det == 0) begin
				r.x = '0; r.y = '0; r.code = CODE_DEGEN;
				return r;
			end
			r.x = OUT_W'(fixed_quotient(b2 * c1 - b1 * c2, det));
			r.y = OUT_W'(fixed_quotient(height * det - (a1 * c2 - a2 * c1), det));
			r.code = CODE_PROJ;
			return r;
		endfunction

		function void note_point(logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py);
			expected_q.push_back(clamp(px, py));
		endfunction

		function void check_result(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y,
				logic [1:0] code);
			clamp_result_t e;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result beat: x=%0d y=%0d code=%0d", x, y, code);
				return;
			end
			e = expected_q.pop_front();
			if (x !== e.x || y !== e.y || code !== e.code) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("result %0d: expected x=%0d y=%0d code=%0d, got x=%0d y=%0d code=%0d",
						checked, e.x, e.y, e.code, x, y, code);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [IN_W-1:0] point_x = '0;
	logic signed [IN_W-1:0] point_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] out_x;
	logic signed [OUT_W-1:0] out_y;
	logic [1:0] case_code;

	clamp_scoreboard sb = new();
	int idle_mode = IDLE_NONE;
	int cycles = 0;
	int sent = 0;
	int phases = 0;

	clamp_point_to_triangle_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .point_x(point_x), .point_y(point_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .case_code(case_code)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check accepted beats, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_x, out_y, case_code);
		if (!arst_n)
			out_ready <= 1'b0;
		else if (idle_mode == IDLE_RECV)
			out_ready <= ($urandom_range(99) >= 80);
		else if (idle_mode == IDLE_BOTH)
			out_ready <= ($urandom_range(99) >= 8);
		else
			out_ready <= 1'b1;
	end

	// Leaves cfg_valid high; the caller drops it after the last beat.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DAT_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, CFG_DAT_W'(value));
	endtask

	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_triangle(int ax, int ay, int lx, int ly, int rx, int ry, int h);
		in_valid <= 1'b0;
		settle();
		write_reg(REG_APEX_X, ax);
		write_reg(REG_APEX_Y, ay);
		write_reg(REG_LEFT_X, lx);
		write_reg(REG_LEFT_Y, ly);
		write_reg(REG_RIGHT_X, rx);
		write_reg(REG_RIGHT_Y, ry);
		write_reg(REG_HEIGHT, h);
		cfg_valid <= 1'b0;
		phases++;
	endtask

	task automatic send_point(int x, int y);
		int gap;
		gap = 0;
		if (idle_mode == IDLE_SEND)
			while ($urandom_range(99) < 80) gap++;
		else if (idle_mode == IDLE_BOTH)
			while ($urandom_range(99) < 8) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= IN_W'(x);
		point_y <= IN_W'(y);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_point(IN_W'(x), IN_W'(y));
		sent++;
	endtask

	function automatic int fit14(longint v);
		if (v > 8191) return 8191;
		if (v < -8192) return -8192;
		return int'(v);
	endfunction

	// Points on an edge line: corner plus edge multiples, or the edge midpoint.
	task automatic send_on_edge();
		longint x0, y0, x1, y1, k;
		case ($urandom_range(2))
			0: begin x0 = sb.left_x; y0 = sb.left_y; x1 = sb.apex_x; y1 = sb.apex_y; end
			1: begin x0 = sb.right_x; y0 = sb.right_y; x1 = sb.apex_x; y1 = sb.apex_y; end
			default: begin x0 = sb.left_x; y0 = sb.left_y; x1 = sb.right_x; y1 = sb.right_y; end
		endcase
		k = longint'($urandom_range(6)) - 2;
		if (x1 - x0 == 0 || y1 - y0 == 0 || $urandom_range(1))
			send_point(fit14(x0 + k * (x1 - x0)), fit14(y0 + k * (y1 - y0)));
		else if ((x1 - x0) % 2 == 0 && (y1 - y0) % 2 == 0)
			send_point(int'(x0 + (x1 - x0) / 2), int'(y0 + (y1 - y0) / 2));
		else
			send_point(int'(x1), int'(y1));
	endtask

	task automatic send_random(int count);
		int lo_x, hi_x, lo_y, hi_y, pick;
		lo_x = int'(sb.apex_x); hi_x = lo_x;
		lo_y = int'(sb.apex_y); hi_y = lo_y;
		if (sb.left_x < lo_x) lo_x = int'(sb.left_x);
		if (sb.right_x < lo_x) lo_x = int'(sb.right_x);
		if (sb.left_x > hi_x) hi_x = int'(sb.left_x);
		if (sb.right_x > hi_x) hi_x = int'(sb.right_x);
		if (sb.left_y < lo_y) lo_y = int'(sb.left_y);
		if (sb.right_y < lo_y) lo_y = int'(sb.right_y);
		if (sb.left_y > hi_y) hi_y = int'(sb.left_y);
		if (sb.right_y > hi_y) hi_y = int'(sb.right_y);
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 65)
				send_point(lo_x - 64 + int'($urandom_range(hi_x - lo_x + 128)),
					lo_y - 64 + int'($urandom_range(hi_y - lo_y + 128)));
			else if (pick < 80)
				send_on_edge();
			else
				send_point(int'($urandom_range(16383)) - 8192, int'($urandom_range(16383)) - 8192);
		end
	endtask

	task automatic random_triangle();
		load_triangle($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4096, 1));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points against the reset triangle.
		send_point(512, 100);
		send_point(100, 800);
		send_point(924, 800);
		send_point(512, 500);
		send_point(0, 500);
		send_point(1000, 500);
		send_point(512, 1000);
		send_point(512, 0);
		send_point(0, 900);
		send_point(1023, 900);
		send_point(924, -600);
		send_point(306, 450);
		send_point(718, 450);
		send_point(0, 800);
		send_point(1000, 800);
		send_point(500, 800);
		send_point(-8192, -8192);
		send_point(8191, 8191);
		send_point(-8192, 8191);
		send_point(8191, -8192);
		send_point(0, 0);
		send_point(-1, -1);

		idle_mode = IDLE_SEND;
		send_random(200);

		idle_mode = IDLE_RECV;
		random_triangle();
		send_random(250);

		// Widest triangle and tallest flip height.
		idle_mode = IDLE_BOTH;
		load_triangle(4095, 0, 0, 4095, 4095, 4095, 4096);
		send_point(-8192, -8192);
		send_point(8191, 8191);
		send_random(200);

		// Everything at zero and the smallest height: collapsed triangle.
		idle_mode = IDLE_NONE;
		load_triangle(0, 0, 0, 0, 0, 0, 1);
		send_random(120);

		// Collinear corners.
		idle_mode = IDLE_SEND;
		load_triangle(100, 100, 200, 200, 300, 300, 2048);
		send_random(120);

		idle_mode = IDLE_NONE;
		random_triangle();
		send_random(250);

		idle_mode = IDLE_RECV;
		random_triangle();
		send_random(200);

		idle_mode = IDLE_BOTH;
		random_triangle();
		send_random(200);

		idle_mode = IDLE_NONE;
		load_triangle(512, 100, 100, 800, 924, 800, 1024);
		send_random(150);

		in_valid <= 1'b0;
		settle();

		$display("%0d points over %0d register settings, %0d results checked", sent,
			phases + 1, sb.checked);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
